FILE: rtl/rpvg_pkg.sv
package rpvg_pkg;

   localparam int MAX_SIDES_DEF        = 64;
   localparam int CORDIC_STEPS_DEF     = 16;
   localparam int RADIUS_FRAC_BITS_DEF = 8;

   localparam int SIDE_W   = 7;
   localparam int RADIUS_W = 20;
   localparam int COORD_W  = 14;
   localparam int CENTER_W = 12;
   localparam int ANGLE_W  = 16;
   localparam int STEP_W   = 5;
   localparam int TRIG_W   = 32;
   localparam int ZW       = 26;
   localparam int TRIG_ONE = 30;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

   localparam logic CSR_CENTER_X = 1'b0;
   localparam logic CSR_CENTER_Y = 1'b1;

   typedef logic [SIDE_W-1:0]          side_type;
   typedef logic [RADIUS_W-1:0]        radius_type;
   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic [CENTER_W-1:0]        center_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_FOLD,
      ST_ROT,
      ST_MULX,
      ST_ACCX,
      ST_MULY,
      ST_ACCY,
      ST_SQX,
      ST_SQY,
      ST_SQINIT,
      ST_SQRT,
      ST_EMIT
   } state_type;

   // arctangent of 2^-k in units of 2^-24 turn, rounded to nearest
   function automatic logic [21:0] atan_turn24(input logic [STEP_W-1:0] k);
      logic [21:0] v;
      case (k)
         5'd0:    v = 22'd2097152;
         5'd1:    v = 22'd1238021;
         5'd2:    v = 22'd654136;
         5'd3:    v = 22'd332050;
         5'd4:    v = 22'd166669;
         5'd5:    v = 22'd83416;
         5'd6:    v = 22'd41718;
         5'd7:    v = 22'd20860;
         5'd8:    v = 22'd10430;
         5'd9:    v = 22'd5215;
         5'd10:   v = 22'd2608;
         5'd11:   v = 22'd1304;
         5'd12:   v = 22'd652;
         5'd13:   v = 22'd326;
         5'd14:   v = 22'd163;
         5'd15:   v = 22'd81;
         5'd16:   v = 22'd41;
         5'd17:   v = 22'd20;
         5'd18:   v = 22'd10;
         5'd19:   v = 22'd5;
         5'd20:   v = 22'd3;
         5'd21:   v = 22'd1;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/rpvg_if.sv
interface rpvg_req_if;
   import rpvg_pkg::*;
   logic       valid;
   logic       ready;
   side_type   side_count;
   radius_type circle_radius;
   modport source (output valid, side_count, circle_radius, input ready);
   modport sink (input valid, side_count, circle_radius, output ready);
endinterface

interface rpvg_rsp_if;
   import rpvg_pkg::*;
   logic       valid;
   logic       ready;
   coord_type  vertex_x;
   coord_type  vertex_y;
   logic       last_vertex;
   radius_type next_radius;
   modport source (output valid, vertex_x, vertex_y, last_vertex, next_radius, input ready);
   modport sink (input valid, vertex_x, vertex_y, last_vertex, next_radius, output ready);
endinterface

FILE: rtl/regular_polygon_vertex_generator.sv
// Sequence: an accepted polygon runs 16 divide steps for the angle, 1 fold, CORDIC_STEPS
// rotation steps and 4 multiply/accumulate steps before each vertex is emitted; the last
// vertex also squares its offsets and takes a square root for next_radius. Only one polygon
// transaction is in flight at a time; the divider, CORDIC and multiplier are reused per vertex.
// Reset: synchronous, active high; clears the sequencer and loads center 512, 384.
module regular_polygon_vertex_generator #(
   parameter int MAX_SIDES        = rpvg_pkg::MAX_SIDES_DEF,
   parameter int CORDIC_STEPS     = rpvg_pkg::CORDIC_STEPS_DEF,
   parameter int RADIUS_FRAC_BITS = rpvg_pkg::RADIUS_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   rpvg_req_if.sink                    req,
   rpvg_rsp_if.source                  rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rpvg_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [rpvg_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [rpvg_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import rpvg_pkg::*;

   localparam int NW    = $clog2(MAX_SIDES + 1);   // side count register
   localparam int IW    = $clog2(MAX_SIDES);       // vertex index
   localparam int RW    = NW + 1;                  // divider remainder, one bit headroom
   localparam int SH    = TRIG_ONE + RADIUS_FRAC_BITS;
   localparam int VW    = (SH + 14 > 56) ? SH + 14 : 56;
   localparam int QW    = VW - SH;
   localparam int MAW   = RADIUS_W + 1;
   localparam int PW    = MAW + TRIG_W;
   localparam int DW    = 16;                      // center-relative doubled midpoint
   localparam int SQ_W  = 32 + 2 * RADIUS_FRAC_BITS;

   localparam logic signed [QW-1:0] COORD_MAX = QW'(8191);
   localparam logic signed [QW-1:0] COORD_MIN = -COORD_MAX - QW'(1);

   // ---------------------------------------------------------------- registers
   state_type              state_ff, state_in;
   center_type             cx_ff, cx_in, cy_ff, cy_in;
   logic [NW-1:0]          n_ff, n_in;
   radius_type             r_ff, r_in;
   logic [IW-1:0]          i_ff, i_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [ANGLE_W-1:0]     quot_ff, quot_in;
   logic signed [TRIG_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]   z_ff, z_in;
   logic                   neg_ff, neg_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   coord_type              vx_ff, vx_in, vy_ff, vy_in;
   coord_type              vx0_ff, vx0_in, vy0_ff, vy0_in;
   coord_type              vx1_ff, vx1_in, vy1_ff, vy1_in;
   logic [31:0]            acc_ff, acc_in;
   logic [SQ_W-1:0]        sv_ff, sv_in, res_ff, res_in, bit_ff, bit_in;
   radius_type             nr_ff, nr_in;

   // ---------------------------------------------------------------- control decode
   logic req_fire, rsp_fire, is_last, csr_wr;

   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = (state_ff == ST_EMIT);
      csr_pready = 1'b1;
   end

   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign is_last  = (NW'(i_ff) == NW'(n_ff - NW'(1)));
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign rsp.vertex_x    = vx_ff;
   assign rsp.vertex_y    = vy_ff;
   assign rsp.last_vertex = is_last;
   assign rsp.next_radius = is_last ? nr_ff : '0;

   assign csr_prdata = (csr_paddr[2] == CSR_CENTER_Y) ? CSR_DW'(cy_ff) : CSR_DW'(cx_ff);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == STEP_W'(ANGLE_W - 1)) state_in = ST_FOLD;
         ST_FOLD:   state_in = ST_ROT;
         ST_ROT:    if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) state_in = ST_MULX;
         ST_MULX:   state_in = ST_ACCX;
         ST_ACCX:   state_in = ST_MULY;
         ST_MULY:   state_in = ST_ACCY;
         ST_ACCY:   state_in = is_last ? ST_SQX : ST_EMIT;
         ST_SQX:    state_in = ST_SQY;
         ST_SQY:    state_in = ST_SQINIT;
         ST_SQINIT: state_in = ST_SQRT;
         ST_SQRT:   if (bit_ff == '0) state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_fire) state_in = is_last ? ST_IDLE : ST_DIV;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- shared datapath
   logic [RW-1:0]          rem_dbl;
   logic signed [ANGLE_W:0] ang, ang_fold;
   logic                   fold_neg;
   logic signed [TRIG_W-1:0] trig_c, trig_s;
   logic signed [MAW-1:0]  mul_a;
   logic signed [TRIG_W-1:0] mul_b;
   logic signed [VW-1:0]   v_sum;
   logic signed [QW-1:0]   q;
   coord_type              coord_sat;
   logic signed [DW-1:0]   dx, dy;
   logic [SQ_W-1:0]        trial;
   logic [SQ_W-1:0]        half_res;
   logic signed [ZW-1:0]   atan_z;

   always_comb begin
      // restoring divide step: doubled remainder against n
      rem_dbl = {rem_ff[RW-2:0], 1'b0};

      // fold the turn fraction into [-1/4, +1/4]
      ang      = (ANGLE_W+1)'(signed'(quot_ff));
      ang_fold = ang;
      fold_neg = 1'b0;
      if (ang > (ANGLE_W+1)'(16384)) begin
         ang_fold = ang - (ANGLE_W+1)'(32768);
         fold_neg = 1'b1;
      end else if (ang < -(ANGLE_W+1)'(16384)) begin
         ang_fold = ang + (ANGLE_W+1)'(32768);
         fold_neg = 1'b1;
      end

      trig_c = neg_ff ? -x_ff : x_ff;
      trig_s = neg_ff ? -y_ff : y_ff;

      dx = DW'(vx0_ff) + DW'(vx1_ff) - signed'({3'b000, cx_ff, 1'b0});
      dy = DW'(vy0_ff) + DW'(vy1_ff) - signed'({3'b000, cy_ff, 1'b0});

      // one multiplier, operands picked by the sequencer
      case (state_ff)
         ST_MULX: begin mul_a = signed'({1'b0, r_ff}); mul_b = trig_c; end
         ST_MULY: begin mul_a = signed'({1'b0, r_ff}); mul_b = trig_s; end
         ST_SQX:  begin mul_a = MAW'(dx); mul_b = TRIG_W'(dx); end
         ST_SQY:  begin mul_a = MAW'(dy); mul_b = TRIG_W'(dy); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase

      // center * 2^SH + r * trig, truncated toward zero, saturated
      v_sum = signed'(VW'((state_ff == ST_ACCY) ? cy_ff : cx_ff)) <<< SH;
      v_sum = v_sum + VW'(prod_ff);
      if (v_sum < 0) v_sum = v_sum + signed'(VW'({SH{1'b1}}));
      q = QW'(v_sum >>> SH);
      if (q > COORD_MAX)      coord_sat = COORD_W'(COORD_MAX);
      else if (q < COORD_MIN) coord_sat = COORD_W'(COORD_MIN);
      else                    coord_sat = COORD_W'(q);

      trial    = res_ff + bit_ff;
      half_res = res_ff >> 1;
      atan_z   = ZW'(signed'({1'b0, atan_turn24(cnt_ff)}));
   end

   always_comb begin
      cx_in   = cx_ff;   cy_in   = cy_ff;
      n_in    = n_ff;    r_in    = r_ff;
      i_in    = i_ff;    cnt_in  = cnt_ff;
      rem_in  = rem_ff;  quot_in = quot_ff;
      x_in    = x_ff;    y_in    = y_ff;    z_in = z_ff;  neg_in = neg_ff;
      prod_in = prod_ff;
      vx_in   = vx_ff;   vy_in   = vy_ff;
      vx0_in  = vx0_ff;  vy0_in  = vy0_ff;  vx1_in = vx1_ff;  vy1_in = vy1_ff;
      acc_in  = acc_ff;
      sv_in   = sv_ff;   res_in  = res_ff;  bit_in = bit_ff;
      nr_in   = nr_ff;

      if (csr_wr) begin
         if (csr_paddr[2] == CSR_CENTER_X) cx_in = csr_pwdata[CENTER_W-1:0];
         else                              cy_in = csr_pwdata[CENTER_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            // clamp side count into [3, MAX_SIDES]
            if (req.side_count < SIDE_W'(3))              n_in = NW'(3);
            else if (req.side_count > SIDE_W'(MAX_SIDES)) n_in = NW'(MAX_SIDES);
            else                                          n_in = NW'(req.side_count);
            r_in   = req.circle_radius;
            i_in   = '0;
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            if (rem_dbl >= RW'(n_ff)) rem_in = rem_dbl - RW'(n_ff);
            else                      rem_in = rem_dbl;
            quot_in = {quot_ff[ANGLE_W-2:0], rem_dbl >= RW'(n_ff)};
            cnt_in  = (cnt_ff == STEP_W'(ANGLE_W - 1)) ? '0 : cnt_ff + STEP_W'(1);
         end
         ST_FOLD: begin
            neg_in = fold_neg;
            z_in = ZW'(ang_fold) <<< 8;
            x_in = CORDIC_GAIN;
            y_in = '0;
         end
         ST_ROT: begin
            if (z_ff >= 0) begin
               x_in = x_ff - (y_ff >>> cnt_ff);
               y_in = y_ff + (x_ff >>> cnt_ff);
               z_in = z_ff - atan_z;
            end else begin
               x_in = x_ff + (y_ff >>> cnt_ff);
               y_in = y_ff - (x_ff >>> cnt_ff);
               z_in = z_ff + atan_z;
            end
            cnt_in = (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) ? '0 : cnt_ff + STEP_W'(1);
         end
         ST_MULX, ST_MULY, ST_SQX: prod_in = PW'(mul_a) * PW'(mul_b);
         ST_ACCX: begin
            vx_in = coord_sat;
            if (i_ff == IW'(0)) vx0_in = coord_sat;
            if (i_ff == IW'(1)) vx1_in = coord_sat;
         end
         ST_ACCY: begin
            vy_in = coord_sat;
            if (i_ff == IW'(0)) vy0_in = coord_sat;
            if (i_ff == IW'(1)) vy1_in = coord_sat;
         end
         ST_SQY: begin
            acc_in  = 32'(prod_ff);
            prod_in = PW'(mul_a) * PW'(mul_b);
         end
         ST_SQINIT: begin
            sv_in  = SQ_W'(acc_ff + 32'(prod_ff)) << (2 * RADIUS_FRAC_BITS);
            res_in = '0;
            bit_in = SQ_W'(1) << (SQ_W - 2);
         end
         ST_SQRT: begin
            if (bit_ff == '0) begin
               if ((half_res >> RADIUS_W) != '0) nr_in = '1;
               else                              nr_in = RADIUS_W'(half_res);
            end else if (sv_ff >= trial) begin
               sv_in  = sv_ff - trial;
               res_in = half_res + bit_ff;
               bit_in = bit_ff >> 2;
            end else begin
               res_in = half_res;
               bit_in = bit_ff >> 2;
            end
         end
         ST_EMIT: begin
            if (rsp_fire && !is_last) begin
               i_in   = i_ff + IW'(1);
               rem_in = RW'(i_ff + IW'(1));
               cnt_in = '0;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cx_ff    <= CENTER_W'(512);
         cy_ff    <= CENTER_W'(384);
      end else begin
         state_ff <= state_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;    r_ff    <= r_in;
      i_ff    <= i_in;    cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;  quot_ff <= quot_in;
      x_ff    <= x_in;    y_ff    <= y_in;    z_ff <= z_in;  neg_ff <= neg_in;
      prod_ff <= prod_in;
      vx_ff   <= vx_in;   vy_ff   <= vy_in;
      vx0_ff  <= vx0_in;  vy0_ff  <= vy0_in;  vx1_ff <= vx1_in;  vy1_ff <= vy1_in;
      acc_ff  <= acc_in;
      sv_ff   <= sv_in;   res_ff  <= res_in;  bit_ff <= bit_in;
      nr_ff   <= nr_in;
   end

endmodule
